// ===== sv/rgb2hsl_pkg.sv =====
// shared constants and types for the rgb to hsl converter
`default_nettype none
package rgb2hsl_pkg;
	localparam int unsigned CH_W  = 8;
	localparam int unsigned HUE_W = 9;
	localparam int unsigned PCT_W = 7;
	localparam int unsigned SUM_W = CH_W + 1;

	localparam int unsigned DIV_NW = 15;
	localparam int unsigned DIV_DW = CH_W;
	localparam int unsigned DIV_QW = PCT_W;

	localparam logic [HUE_W-1:0] HUE_RED   = 9'd0;
	localparam logic [HUE_W-1:0] HUE_GREEN = 9'd120;
	localparam logic [HUE_W-1:0] HUE_BLUE  = 9'd240;
	localparam logic [HUE_W-1:0] HUE_WRAP  = 9'd360;
	localparam int unsigned HUE_SPAN = 60;

	localparam int unsigned PCT       = 100;
	localparam int unsigned SAT_SPLIT = 255;
	localparam int unsigned LIT_DIV   = 510;
	localparam int unsigned LIT_RECIP = 25700;
	localparam int unsigned LIT_SHIFT = 17;
	localparam int unsigned LIT_PW    = LIT_SHIFT + PCT_W;
	localparam int unsigned LIT_CW    = 16;

	typedef struct packed {
		logic [HUE_W-1:0] base;
		logic             neg;
		logic             grey;
		logic [SUM_W-1:0] sum;
		logic [PCT_W-1:0] lit0;
	} hue_side_t;
endpackage
`default_nettype wire

// ===== sv/rgb2hsl_prep.sv =====
// front stages: max, min, sector select, divider operands and lightness estimate
`default_nettype none
module rgb2hsl_prep (
	input  logic                                 clk,
	input  logic [1:0]                           en,
	input  logic [rgb2hsl_pkg::CH_W-1:0]         red,
	input  logic [rgb2hsl_pkg::CH_W-1:0]         green,
	input  logic [rgb2hsl_pkg::CH_W-1:0]         blue,
	output logic [rgb2hsl_pkg::DIV_NW-1:0]       hue_num,
	output logic [rgb2hsl_pkg::DIV_DW-1:0]       hue_dvs,
	output logic [rgb2hsl_pkg::DIV_NW-1:0]       sat_num,
	output logic [rgb2hsl_pkg::DIV_DW-1:0]       sat_dvs,
	output rgb2hsl_pkg::hue_side_t               side
);
	import rgb2hsl_pkg::*;

	logic [CH_W-1:0]  mx, mn, x;
	logic [HUE_W-1:0] base;
	logic             neg;

	logic [CH_W-1:0]  d_s1, x_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [HUE_W-1:0] base_s1;
	logic             neg_s1;

	logic [DIV_NW-1:0] hnum, snum;
	logic [CH_W-1:0]   den;
	logic [LIT_PW-1:0] lprod;
	hue_side_t         side_w;

	logic [DIV_NW-1:0] hue_num_s2, sat_num_s2;
	logic [CH_W-1:0]   d_s2, den_s2;
	hue_side_t         side_s2;

	always_comb begin
		if (red >= green && red >= blue) begin
			mx = red;
			mn = (green < blue) ? green : blue;
			if (green > blue) begin
				x    = green - blue;
				base = HUE_RED;
				neg  = 1'b0;
			end else begin
				x    = blue - green;
				base = HUE_WRAP;
				neg  = 1'b1;
			end
		end else if (green >= blue) begin
			mx   = green;
			mn   = (red < blue) ? red : blue;
			base = HUE_GREEN;
			if (blue >= red) begin
				x   = blue - red;
				neg = 1'b0;
			end else begin
				x   = red - blue;
				neg = 1'b1;
			end
		end else begin
			mx   = blue;
			mn   = (red < green) ? red : green;
			base = HUE_BLUE;
			if (red >= green) begin
				x   = red - green;
				neg = 1'b0;
			end else begin
				x   = green - red;
				neg = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d_s1    <= mx - mn;
			sum_s1  <= SUM_W'(mx) + SUM_W'(mn);
			x_s1    <= x;
			base_s1 <= base;
			neg_s1  <= neg;
		end
	end

	// ceil for the descending side comes from adding d - 1 to the dividend
	always_comb begin
		hnum = DIV_NW'(x_s1) * DIV_NW'(HUE_SPAN);
		if (neg_s1)
			hnum = hnum + DIV_NW'(d_s1) - DIV_NW'(1);
		snum = DIV_NW'(d_s1) * DIV_NW'(PCT);
		if (sum_s1 < SUM_W'(SAT_SPLIT))
			den = sum_s1[CH_W-1:0];
		else
			den = CH_W'(10'(LIT_DIV) - 10'(sum_s1));
		lprod       = LIT_PW'(sum_s1) * LIT_PW'(LIT_RECIP);
		side_w.base = base_s1;
		side_w.neg  = neg_s1;
		side_w.grey = (d_s1 == '0);
		side_w.sum  = sum_s1;
		side_w.lit0 = lprod[LIT_SHIFT +: PCT_W];
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			hue_num_s2 <= hnum;
			sat_num_s2 <= snum;
			d_s2       <= d_s1;
			den_s2     <= den;
			side_s2    <= side_w;
		end
	end

	assign hue_num = hue_num_s2;
	assign hue_dvs = d_s2;
	assign sat_num = sat_num_s2;
	assign sat_dvs = den_s2;
	assign side    = side_s2;
endmodule
`default_nettype wire

// ===== sv/rgb2hsl_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module rgb2hsl_div #(
	parameter int unsigned NW = rgb2hsl_pkg::DIV_NW,
	parameter int unsigned DW = rgb2hsl_pkg::DIV_DW,
	parameter int unsigned QW = rgb2hsl_pkg::DIV_QW,
	parameter int unsigned SW = 1
) (
	input  logic          clk,
	input  logic [QW-1:0] en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] dvs,
	input  logic [SW-1:0] side_in,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);
	localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

	logic [NW-1:0] rem_s  [QW];
	logic [DW-1:0] dvs_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stg
		logic [NW-1:0] rem_i;
		logic [DW-1:0] dvs_i;
		logic [QW-1:0] quo_i;
		logic [SW-1:0] side_i;
		logic [CW-1:0] trial, rem_w;
		logic          take;

		if (k == 0) begin : g_first
			assign rem_i  = num;
			assign dvs_i  = dvs;
			assign quo_i  = '0;
			assign side_i = side_in;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign dvs_i  = dvs_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = CW'(dvs_i) << (QW - 1 - k);
		assign rem_w = CW'(rem_i);
		assign take  = (rem_w >= trial);

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= take ? NW'(rem_w - trial) : rem_i;
				dvs_s[k]  <= dvs_i;
				quo_s[k]  <= quo_i | (QW'(take) << (QW - 1 - k));
				side_s[k] <= side_i;
			end
		end
	end

	assign quo      = quo_s[QW-1];
	assign side_out = side_s[QW-1];
endmodule
`default_nettype wire

// ===== sv/rgb2hsl_fin.sv =====
// output stage: hue assembly, grey override, lightness correction
`default_nettype none
module rgb2hsl_fin (
	input  logic                              clk,
	input  logic                              en,
	input  logic [rgb2hsl_pkg::DIV_QW-1:0]    hue_quo,
	input  logic [rgb2hsl_pkg::DIV_QW-1:0]    sat_quo,
	input  logic                              sat_grey,
	input  rgb2hsl_pkg::hue_side_t            side,
	output logic [rgb2hsl_pkg::HUE_W-1:0]     hue,
	output logic [rgb2hsl_pkg::PCT_W-1:0]     saturation,
	output logic [rgb2hsl_pkg::PCT_W-1:0]     lightness
);
	import rgb2hsl_pkg::*;

	logic [HUE_W-1:0]  hue_w;
	logic [PCT_W-1:0]  sat_w, lit_w;
	logic [LIT_CW-1:0] pct_sum, lit_back, lit_rem;
	logic [HUE_W-1:0]  hue_q;
	logic [PCT_W-1:0]  sat_q, lit_q;

	always_comb begin
		if (side.grey)
			hue_w = '0;
		else if (side.neg)
			hue_w = side.base - HUE_W'(hue_quo);
		else
			hue_w = side.base + HUE_W'(hue_quo);
		sat_w = sat_grey ? '0 : PCT_W'(sat_quo);
		// estimate is exact or one low
		pct_sum  = LIT_CW'(side.sum) * LIT_CW'(PCT);
		lit_back = LIT_CW'(side.lit0) * LIT_CW'(LIT_DIV);
		lit_rem  = pct_sum - lit_back;
		lit_w    = (lit_rem >= LIT_CW'(LIT_DIV)) ? side.lit0 + PCT_W'(1) : side.lit0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= hue_w;
			sat_q <= sat_w;
			lit_q <= lit_w;
		end
	end

	assign hue        = hue_q;
	assign saturation = sat_q;
	assign lightness  = lit_q;
endmodule
`default_nettype wire

// ===== sv/rgb_to_hsl_converter_core.sv =====
// top level of the rgb to hsl converter
//
// Converts one 8-bit rgb pixel per beat into hue (0..360 degrees), saturation and
// lightness (0..100 percent), all truncated toward zero. Accepts a pixel every clock
// while the output is not stalled. The pipeline is two front stages, a 7-stage divider
// for hue and saturation (one quotient bit per stage, both run side by side) and a
// registered output. Each stage has a valid bit and moves on when the stage after it
// is empty or moving, so bubbles close up while a result is held at the output.
`default_nettype none
module rgb_to_hsl_converter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  logic [rgb2hsl_pkg::CH_W-1:0]      red,
	input  logic [rgb2hsl_pkg::CH_W-1:0]      green,
	input  logic [rgb2hsl_pkg::CH_W-1:0]      blue,
	output logic                              hsl_valid,
	input  logic                              hsl_ready,
	output logic [rgb2hsl_pkg::HUE_W-1:0]     hue,
	output logic [rgb2hsl_pkg::PCT_W-1:0]     saturation,
	output logic [rgb2hsl_pkg::PCT_W-1:0]     lightness
);
	import rgb2hsl_pkg::*;

	localparam int unsigned NSTG = 2 + DIV_QW + 1;

	logic [NSTG-1:0]   vld_q;
	logic [NSTG-1:0]   adv;

	logic [DIV_NW-1:0] hue_num, sat_num;
	logic [DIV_DW-1:0] hue_dvs, sat_dvs;
	hue_side_t         side_p, side_d;
	logic [DIV_QW-1:0] hue_quo, sat_quo;
	logic              sat_grey;

	always_comb begin
		adv[NSTG-1] = ~vld_q[NSTG-1] | hsl_ready;
		for (int i = NSTG - 2; i >= 0; i--)
			adv[i] = ~vld_q[i] | adv[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= pix_valid;
			for (int i = 1; i < NSTG; i++)
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	assign pix_ready = adv[0];
	assign hsl_valid = vld_q[NSTG-1];

	rgb2hsl_prep u_prep (
		.clk     (clk),
		.en      (adv[1:0]),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.hue_num (hue_num),
		.hue_dvs (hue_dvs),
		.sat_num (sat_num),
		.sat_dvs (sat_dvs),
		.side    (side_p)
	);

	rgb2hsl_div #(
		.NW (DIV_NW),
		.DW (DIV_DW),
		.QW (DIV_QW),
		.SW ($bits(hue_side_t))
	) u_div_hue (
		.clk      (clk),
		.en       (adv[2 +: DIV_QW]),
		.num      (hue_num),
		.dvs      (hue_dvs),
		.side_in  (side_p),
		.quo      (hue_quo),
		.side_out (side_d)
	);

	rgb2hsl_div #(
		.NW (DIV_NW),
		.DW (DIV_DW),
		.QW (DIV_QW),
		.SW (1)
	) u_div_sat (
		.clk      (clk),
		.en       (adv[2 +: DIV_QW]),
		.num      (sat_num),
		.dvs      (sat_dvs),
		.side_in  (side_p.grey),
		.quo      (sat_quo),
		.side_out (sat_grey)
	);

	rgb2hsl_fin u_fin (
		.clk        (clk),
		.en         (adv[NSTG-1]),
		.hue_quo    (hue_quo),
		.sat_quo    (sat_quo),
		.sat_grey   (sat_grey),
		.side       (side_d),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness)
	);
endmodule
`default_nettype wire

// ===== sv/rgb2hsl_chk.sv =====
// port-level checks for the rgb to hsl converter, bound to the top level
`default_nettype none
module rgb2hsl_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pix_ready,
	input logic                          hsl_valid,
	input logic                          hsl_ready,
	input logic [rgb2hsl_pkg::HUE_W-1:0] hue,
	input logic [rgb2hsl_pkg::PCT_W-1:0] saturation,
	input logic [rgb2hsl_pkg::PCT_W-1:0] lightness
);
	import rgb2hsl_pkg::*;

	// held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && !hsl_ready |=> hsl_valid && $stable(hue) && $stable(saturation)
			&& $stable(lightness))
		else $error("output beat changed while stalled");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> hue <= HUE_WRAP && saturation <= PCT_W'(PCT)
			&& lightness <= PCT_W'(PCT))
		else $error("result out of range");

	// full lightness only for white, which is grey
	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && lightness == PCT_W'(PCT) |-> hue == '0 && saturation == '0)
		else $error("white pixel with hue or saturation");

	// empty output stage never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!hsl_valid |-> pix_ready)
		else $error("input stalled with empty output");

	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !hsl_valid)
		else $error("output valid right after reset");
endmodule

bind rgb_to_hsl_converter_core rgb2hsl_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_ready  (pix_ready),
	.hsl_valid  (hsl_valid),
	.hsl_ready  (hsl_ready),
	.hue        (hue),
	.saturation (saturation),
	.lightness  (lightness)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the rgb to hsl converter: directed and random pixels checked per field
`timescale 1ns / 100ps
module tb_top;
	import rgb2hsl_pkg::*;

	localparam int unsigned DIRECTED_ROWS    = 24;
	localparam int unsigned RANDOM_ITEMS     = 1426;
	localparam int unsigned CHUNK            = 50;
	localparam int unsigned HOLD_CHUNK       = 8;
	localparam int unsigned PAUSE_CHUNK      = 16;
	localparam int unsigned SINK_HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES     = 24;
	localparam int unsigned STALL_LIMIT      = 5000;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] lit;
	} hsl_t;

	typedef struct packed {
		rgb_t pix;
		bit   typed;
		hsl_t want;
	} pixel_row_t;

	logic             clk;
	logic             arst_n;
	logic             pix_valid;
	logic             pix_ready;
	logic [CH_W-1:0]  red;
	logic [CH_W-1:0]  green;
	logic [CH_W-1:0]  blue;
	logic             hsl_valid;
	logic             hsl_ready;
	logic [HUE_W-1:0] hue;
	logic [PCT_W-1:0] saturation;
	logic [PCT_W-1:0] lightness;

	hsl_t        pixel_want;
	hsl_t        hsl_head;
	hsl_t        hsl_expected [$];
	int unsigned mismatch_count = 0;
	bit          sink_hold = 1'b0;

	pixel_row_t pixel_table [DIRECTED_ROWS] = '{
		'{'{0, 0, 0}, 1, '{0, 0, 0}},
		'{'{255, 255, 255}, 1, '{0, 0, 100}},
		'{'{255, 0, 0}, 1, '{360, 100, 50}},
		'{'{0, 255, 0}, 1, '{120, 100, 50}},
		'{'{0, 0, 255}, 1, '{240, 100, 50}},
		'{'{128, 128, 128}, 1, '{0, 0, 50}},
		'{'{1, 1, 1}, 1, '{0, 0, 0}},
		'{'{254, 254, 254}, 1, '{0, 0, 99}},
		'{'{255, 255, 0}, 0, '{0, 0, 0}},
		'{'{0, 255, 255}, 0, '{0, 0, 0}},
		'{'{255, 0, 255}, 0, '{0, 0, 0}},
		'{'{200, 100, 100}, 0, '{0, 0, 0}},
		'{'{1, 0, 0}, 0, '{0, 0, 0}},
		'{'{255, 254, 254}, 0, '{0, 0, 0}},
		'{'{0, 1, 0}, 0, '{0, 0, 0}},
		'{'{0, 0, 1}, 0, '{0, 0, 0}},
		'{'{255, 0, 1}, 0, '{0, 0, 0}},
		'{'{255, 1, 0}, 0, '{0, 0, 0}},
		'{'{10, 200, 200}, 0, '{0, 0, 0}},
		'{'{100, 50, 200}, 0, '{0, 0, 0}},
		'{'{128, 127, 127}, 0, '{0, 0, 0}},
		'{'{127, 128, 127}, 0, '{0, 0, 0}},
		'{'{255, 255, 1}, 0, '{0, 0, 0}},
		'{'{0, 255, 254}, 0, '{0, 0, 0}}
	};

	rgb_to_hsl_converter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hsl_valid  (hsl_valid),
		.hsl_ready  (hsl_ready),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness)
	);

	function automatic hsl_t predict_hsl(input rgb_t p);
		hsl_t        o;
		int unsigned top;
		int unsigned bot;
		int unsigned span;
		int unsigned total;
		top = p.r;
		if (p.g > top) top = p.g;
		if (p.b > top) top = p.b;
		bot = p.r;
		if (p.g < bot) bot = p.g;
		if (p.b < bot) bot = p.b;
		span = top - bot;
		total = top + bot;
		o.hue = '0;
		o.sat = '0;
		o.lit = PCT_W'((100 * total) / 510);
		if (span != 0) begin
			if (p.r == top) begin
				if (p.g > p.b)
					o.hue = HUE_W'((60 * (p.g - p.b)) / span);
				else
					o.hue = HUE_W'(360 - (60 * (p.b - p.g) + span - 1) / span);
			end else if (p.g == top) begin
				o.hue = HUE_W'((120 * span + 60 * p.b - 60 * p.r) / span);
			end else begin
				o.hue = HUE_W'((240 * span + 60 * p.r - 60 * p.g) / span);
			end
			if (total < 255)
				o.sat = PCT_W'((100 * span) / total);
			else
				o.sat = PCT_W'((100 * span) / (510 - total));
		end
		return o;
	endfunction

	function automatic logic [CH_W-1:0] edge_channel();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd127;
			3: return 8'd128;
			4: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	function automatic rgb_t random_pixel();
		rgb_t            p;
		logic [CH_W-1:0] v;
		p.r = CH_W'($urandom_range(0, 255));
		p.g = CH_W'($urandom_range(0, 255));
		p.b = CH_W'($urandom_range(0, 255));
		v = CH_W'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: begin
				p = '{v, v, v};
			end
			1: begin
				case ($urandom_range(0, 2))
					0: p.g = p.r;
					1: p.b = p.g;
					default: p.r = p.b;
				endcase
			end
			2: begin
				p = '{edge_channel(), edge_channel(), edge_channel()};
			end
			default: ;
		endcase
		return p;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_pixel(input rgb_t p, input hsl_t want, input int unsigned gap);
		if (gap != 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		red <= p.r;
		green <= p.g;
		blue <= p.b;
		pixel_want <= want;
		do @(posedge clk); while (!pix_ready);
		@(negedge clk);
	endtask

	task automatic drain_pause();
		pix_valid <= 1'b0;
		wait (hsl_expected.size() == 0);
		@(negedge clk);
	endtask

	task automatic sink_wait(input int unsigned n);
		do begin
			@(negedge clk);
			n--;
		end while (n != 0 && !sink_hold);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hsl_valid && hsl_ready) begin
				if (hsl_expected.size() == 0) begin
					report_mismatch("unexpected beat, hue", hue, 0);
				end else begin
					hsl_head = hsl_expected.pop_front();
					if (hue !== hsl_head.hue) report_mismatch("hue", hue, hsl_head.hue);
					if (saturation !== hsl_head.sat)
						report_mismatch("saturation", saturation, hsl_head.sat);
					if (lightness !== hsl_head.lit)
						report_mismatch("lightness", lightness, hsl_head.lit);
				end
			end
			if (pix_valid && pix_ready) hsl_expected.push_back(pixel_want);
		end
	end

	initial begin : stall_watch
		int unsigned idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (pix_valid && pix_ready) || (hsl_valid && hsl_ready))
				idle = 0;
			else
				idle++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : hsl_sink
		int unsigned run;
		int unsigned gap;
		hsl_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (sink_hold) begin
				hsl_ready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(negedge clk);
				sink_hold = 1'b0;
			end
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 8);
			hsl_ready <= 1'b1;
			sink_wait(run);
			gap = pick_gap();
			if (gap != 0 && !sink_hold) begin
				hsl_ready <= 1'b0;
				sink_wait(gap);
			end
		end
	end

	initial begin : pixel_source
		rgb_t pix;
		bit   steady;
		pix_valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		pixel_want = '0;
		steady = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		foreach (pixel_table[i])
			send_pixel(pixel_table[i].pix,
				pixel_table[i].typed ? pixel_table[i].want : predict_hsl(pixel_table[i].pix),
				pick_gap());
		drain_pause();
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % CHUNK == 0) begin
				steady = ($urandom_range(0, 3) == 0);
				if (n / CHUNK == HOLD_CHUNK) begin
					sink_hold = 1'b1;
					steady = 1'b1;
				end
				if (n / CHUNK == PAUSE_CHUNK) drain_pause();
			end
			pix = random_pixel();
			send_pixel(pix, predict_hsl(pix), steady ? 0 : pick_gap());
		end
		pix_valid <= 1'b0;
		wait (hsl_expected.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && hsl_expected.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/rgb2hsl_pkg.sv
sv/rgb2hsl_prep.sv
sv/rgb2hsl_div.sv
sv/rgb2hsl_fin.sv
sv/rgb_to_hsl_converter_core.sv
sv/rgb2hsl_chk.sv
tb/tb_top.sv
